// ----- rtl/core/satellite_cn_to_db_defines.svh -----
// Assertion helpers used by the checker of this block.
`ifndef SATELLITE_CN_TO_DB_DEFINES_SVH
`define SATELLITE_CN_TO_DB_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define CN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("satellite_cn_to_db: implication check failed");

// Next-cycle implication, also checked across reset.
`define CN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("satellite_cn_to_db: next-cycle check failed");

`endif

// ----- rtl/core/cntdb_pkg.sv -----
package cntdb_pkg;

  localparam int DIFF_W      = 16;
  localparam int RAD_SHIFT   = 20;
  localparam int RAD_W       = DIFF_W + RAD_SHIFT;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_STAGES = 9;
  localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;
  localparam int FRAC        = 16;
  localparam int LEAD_W      = 15;
  localparam int MUL0_W      = ROOT_W + LEAD_W;
  localparam int Y_W         = 48;
  localparam int PROD_W      = Y_W + ROOT_W + 1;
  localparam int OUT_W       = 20;
  localparam int LATENCY     = 1 + SQRT_STAGES + 2 + 4 * 2 + 1;

  localparam logic [DIFF_W-1:0] OFFSET_RESET = DIFF_W'(3000);
  localparam logic [OUT_W-1:0]  CN_DB_MAX    = OUT_W'(588570);
  localparam logic [LEAD_W-1:0] C_LEAD       = LEAD_W'(16346);

  localparam logic signed [Y_W-1:0] C_K0 = Y_W'(64'd143410 << FRAC);
  localparam logic signed [Y_W-1:0] C_K1 = Y_W'(64'd502590 << FRAC);
  localparam logic signed [Y_W-1:0] C_K2 = Y_W'(64'd889770 << FRAC);
  localparam logic signed [Y_W-1:0] C_K3 = Y_W'(64'd895650 << FRAC);
  localparam logic signed [Y_W-1:0] C_K4 = Y_W'(64'd588570 << FRAC);

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_work_t;

  typedef struct packed {
    logic                  neg;
    logic signed [Y_W-1:0] coef;
  } horner_coef_t;

endpackage

// ----- rtl/core/cntdb_sqrt_stage.sv -----
module cntdb_sqrt_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  cntdb_pkg::sqrt_work_t  in_work,
  output logic                   out_valid,
  output cntdb_pkg::sqrt_work_t  out_work
);

  cntdb_pkg::sqrt_work_t work_next;

  // One restoring digit step: bring down two radicand bits, try root*4+1.
  function automatic cntdb_pkg::sqrt_work_t sqrt_step(input cntdb_pkg::sqrt_work_t w);
    cntdb_pkg::sqrt_work_t     r;
    logic [cntdb_pkg::REM_W+1:0] shifted;
    logic [cntdb_pkg::REM_W+1:0] trial;
    r       = w;
    shifted = {w.rem, w.rad[cntdb_pkg::RAD_W-1 -: 2]};
    trial   = {2'b00, w.root, 2'b01};
    if (shifted >= trial) begin
      r.rem  = cntdb_pkg::REM_W'(shifted - trial);
      r.root = {w.root[cntdb_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cntdb_pkg::REM_W'(shifted);
      r.root = {w.root[cntdb_pkg::ROOT_W-2:0], 1'b0};
    end
    r.rad = w.rad << 2;
    return r;
  endfunction

  always_comb begin
    work_next = in_work;
    for (int i = 0; i < cntdb_pkg::SQRT_STEPS; i++) begin
      work_next = sqrt_step(work_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_work <= work_next;
  end

endmodule

// ----- rtl/core/cntdb_horner_step.sv -----
module cntdb_horner_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [cntdb_pkg::ROOT_W-1:0]      x_in,
  input  logic signed [cntdb_pkg::Y_W-1:0]  y_in,
  input  cntdb_pkg::horner_coef_t           coef,
  output logic                              out_valid,
  output logic [cntdb_pkg::ROOT_W-1:0]      x_out,
  output logic signed [cntdb_pkg::Y_W-1:0]  y_out
);

  logic signed [cntdb_pkg::PROD_W-1:0] prod_next;
  logic signed [cntdb_pkg::PROD_W-1:0] prod;
  logic signed [cntdb_pkg::PROD_W-1:0] prod_shifted;
  logic signed [cntdb_pkg::Y_W-1:0]    term;
  logic signed [cntdb_pkg::Y_W-1:0]    y_next;
  logic [cntdb_pkg::ROOT_W-1:0]        x_mid;
  logic                                valid_mid;

  assign prod_next = $signed({1'b0, x_in}) * y_in;

  // Arithmetic shift floors toward minus infinity.
  assign prod_shifted = prod >>> cntdb_pkg::FRAC;
  assign term         = prod_shifted[cntdb_pkg::Y_W-1:0];
  assign y_next       = coef.neg ? (coef.coef - term) : (term + coef.coef);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_mid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_mid <= in_valid;
      out_valid <= valid_mid;
    end
  end

  always_ff @(posedge clk) begin
    prod  <= prod_next;
    x_mid <= x_in;
    y_out <= y_next;
    x_out <= x_mid;
  end

endmodule

// ----- rtl/core/satellite_cn_to_db.sv -----
// Channel   Direction  Signals                        Transfer
// input     in         start, busy, raw_cn            start && !busy
// result    out        done, cn_db                    done (one cycle, no backpressure)
// config    in         cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// Takes one reading per cycle once busy has dropped after reset.
// Each result passes through the entry register, the square-root pipe (9 stages,
// two root bits each), the lead multiply and subtract, four Horner multiply/add
// stage pairs and the clamp.
// Synchronous reset holds busy high until the first edge after rst drops and
// flushes all valid bits.
// The result side cannot stall, so the pipe never holds.
module satellite_cn_to_db (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [cntdb_pkg::DIFF_W-1:0]     raw_cn,
  output logic                             done,
  output logic [cntdb_pkg::OUT_W-1:0]      cn_db,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cntdb_pkg::DIFF_W-1:0]     cfg_data
);

  logic [cntdb_pkg::DIFF_W-1:0] noise_floor_offset;
  logic                         accept;
  logic [cntdb_pkg::DIFF_W-1:0] diff_next;

  logic                  sq_valid [0:cntdb_pkg::SQRT_STAGES];
  cntdb_pkg::sqrt_work_t sq_work  [0:cntdb_pkg::SQRT_STAGES];

  logic                               lead_valid;
  logic [cntdb_pkg::MUL0_W-1:0]       lead_mul;
  logic [cntdb_pkg::ROOT_W-1:0]       lead_x;
  logic                               y0_valid;
  logic signed [cntdb_pkg::Y_W-1:0]   y0;
  logic [cntdb_pkg::ROOT_W-1:0]       y0_x;

  logic                               hv    [0:4];
  logic [cntdb_pkg::ROOT_W-1:0]       hx    [0:4];
  logic signed [cntdb_pkg::Y_W-1:0]   hy    [0:4];
  cntdb_pkg::horner_coef_t            hcoef [0:3];

  logic [cntdb_pkg::OUT_W-1:0]        cn_db_next;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign diff_next = (raw_cn > noise_floor_offset) ? (raw_cn - noise_floor_offset)
                                                   : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy               <= 1'b1;
      noise_floor_offset <= cntdb_pkg::OFFSET_RESET;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        noise_floor_offset <= cfg_data;
      end
    end
  end

  // Entry stage: clamp the difference and scale it up for the root.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else begin
      sq_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    sq_work[0].rad  <= {diff_next, cntdb_pkg::RAD_SHIFT'(0)};
    sq_work[0].rem  <= '0;
    sq_work[0].root <= '0;
  end

  for (genvar g = 0; g < cntdb_pkg::SQRT_STAGES; g++) begin : g_sqrt
    cntdb_sqrt_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[g]),
      .in_work   (sq_work[g]),
      .out_valid (sq_valid[g+1]),
      .out_work  (sq_work[g+1])
    );
  end

  // Leading term: 16346*x, then drop the constant.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_valid <= 1'b0;
      y0_valid   <= 1'b0;
    end else begin
      lead_valid <= sq_valid[cntdb_pkg::SQRT_STAGES];
      y0_valid   <= lead_valid;
    end
  end

  always_ff @(posedge clk) begin
    lead_mul <= cntdb_pkg::MUL0_W'(sq_work[cntdb_pkg::SQRT_STAGES].root) *
                cntdb_pkg::MUL0_W'(cntdb_pkg::C_LEAD);
    lead_x   <= sq_work[cntdb_pkg::SQRT_STAGES].root;
    y0       <= $signed(cntdb_pkg::Y_W'(lead_mul)) - cntdb_pkg::C_K0;
    y0_x     <= lead_x;
  end

  assign hv[0] = y0_valid;
  assign hx[0] = y0_x;
  assign hy[0] = y0;

  assign hcoef[0] = '{neg: 1'b0, coef: cntdb_pkg::C_K1};
  assign hcoef[1] = '{neg: 1'b0, coef: -cntdb_pkg::C_K2};
  assign hcoef[2] = '{neg: 1'b0, coef: cntdb_pkg::C_K3};
  assign hcoef[3] = '{neg: 1'b1, coef: cntdb_pkg::C_K4};

  for (genvar h = 0; h < 4; h++) begin : g_horner
    cntdb_horner_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (hv[h]),
      .x_in      (hx[h]),
      .y_in      (hy[h]),
      .coef      (hcoef[h]),
      .out_valid (hv[h+1]),
      .x_out     (hx[h+1]),
      .y_out     (hy[h+1])
    );
  end

  // Clamp negatives to zero, then drop the fraction.
  assign cn_db_next = hy[4][cntdb_pkg::Y_W-1] ? '0 : hy[4][cntdb_pkg::FRAC +: cntdb_pkg::OUT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= hv[4];
    end
  end

  always_ff @(posedge clk) begin
    cn_db <= cn_db_next;
  end

endmodule

// ----- rtl/core/satellite_cn_to_db_checker.sv -----
`include "satellite_cn_to_db_defines.svh"

module satellite_cn_to_db_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [cntdb_pkg::OUT_W-1:0]  cn_db
);

  `CN_ASSERT_NXT(a_no_busy_after_reset, !rst, !busy)
  `CN_ASSERT_NXT(a_flush_on_reset, rst, !done)
  `CN_ASSERT_IMP(a_done_has_transfer, done, $past(start && !busy, cntdb_pkg::LATENCY))
  `CN_ASSERT_IMP(a_result_in_range, done, cn_db <= cntdb_pkg::CN_DB_MAX)

endmodule

bind satellite_cn_to_db satellite_cn_to_db_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .cn_db (cn_db)
);

// ----- tb/sv/cn_db_monitor.sv -----
`timescale 1ns / 1ps

module cn_db_monitor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [cntdb_pkg::DIFF_W-1:0] raw_cn,
  input  logic                         done,
  input  logic [cntdb_pkg::OUT_W-1:0]  cn_db,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [cntdb_pkg::DIFF_W-1:0] cfg_data,
  output int                           fail_cnt,
  output int                           pending_cnt
);

  localparam int DIFF_W = cntdb_pkg::DIFF_W;
  localparam int OUT_W  = cntdb_pkg::OUT_W;

  localparam logic [DIFF_W-1:0] RESET_FLOOR = 16'd3000;

  // Horner coefficients in Q16
  localparam longint LEAD_COEF = 64'sd16346;
  localparam longint HORNER_A  = 64'sd143410 <<< 16;
  localparam longint HORNER_B  = 64'sd502590 <<< 16;
  localparam longint HORNER_C  = 64'sd889770 <<< 16;
  localparam longint HORNER_D  = 64'sd895650 <<< 16;
  localparam longint HORNER_E  = 64'sd588570 <<< 16;

  logic [DIFF_W-1:0] floor_ofs;
  logic [OUT_W-1:0]  cn_db_due[$];
  logic [OUT_W-1:0]  want;
  int                errs = 0;

  assign fail_cnt = errs;

  function automatic logic [OUT_W-1:0] cn_db_from_raw(input logic [DIFF_W-1:0] raw,
                                                      input logic [DIFF_W-1:0] ofs);
    logic [DIFF_W-1:0] diff;
    longint unsigned   rad;
    longint unsigned   root;
    longint unsigned   digit;
    longint            x;
    longint            y;
    diff = (raw > ofs) ? raw - ofs : '0;
    rad = {48'd0, diff} << 20;
    // floor square root, two bits per step
    root = 0;
    digit = 64'd1 << 62;
    while (digit > rad) digit = digit >> 2;
    while (digit != 0) begin
      if (rad >= root + digit) begin
        rad = rad - (root + digit);
        root = (root >> 1) + digit;
      end else begin
        root = root >> 1;
      end
      digit = digit >> 2;
    end
    x = longint'(root);
    // arithmetic shifts floor toward minus infinity
    y = LEAD_COEF * x - HORNER_A;
    y = ((x * y) >>> 16) + HORNER_B;
    y = ((x * y) >>> 16) - HORNER_C;
    y = ((x * y) >>> 16) + HORNER_D;
    y = HORNER_E - ((x * y) >>> 16);
    if (y < 0) return '0;
    return OUT_W'(y >>> 16);
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] exp_val);
    $display("%0t cn_db mismatch: %s, got %0d expected %0d", $time, what, got, exp_val);
    errs++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cn_db_due.delete();
      floor_ofs   <= RESET_FLOOR;
      pending_cnt <= 0;
    end else begin
      // compare before queuing a new reading
      if (done) begin
        if (cn_db_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", cn_db, '0);
        end else begin
          want = cn_db_due.pop_front();
          if (cn_db !== want) report_mismatch("cn_db", cn_db, want);
        end
      end
      if (start && !busy) cn_db_due.push_back(cn_db_from_raw(raw_cn, floor_ofs));
      if (cfg_valid && cfg_ready) floor_ofs <= cfg_data;
      pending_cnt <= cn_db_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int DIFF_W      = cntdb_pkg::DIFF_W;
  localparam int OUT_W       = cntdb_pkg::OUT_W;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 100;

  logic              clk;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic [DIFF_W-1:0] raw_cn    = '0;
  logic              cfg_valid = 1'b0;
  logic [DIFF_W-1:0] cfg_data  = '0;
  logic              busy;
  logic              done;
  logic [OUT_W-1:0]  cn_db;
  logic              cfg_ready;
  int                fail_cnt;
  int                pending_cnt;
  int                burst_left  = 0;
  int                idle_cycles = 0;

  satellite_cn_to_db u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .raw_cn    (raw_cn),
    .done      (done),
    .cn_db     (cn_db),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cn_db_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .raw_cn      (raw_cn),
    .done        (done),
    .cn_db       (cn_db),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // end the run when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_reading(input logic [DIFF_W-1:0] v);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // start stays high into the next reading when it follows at once
    start  <= 1'b1;
    raw_cn <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  task automatic write_floor(input logic [DIFF_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DIFF_W-1:0] pick_reading(input logic [DIFF_W-1:0] ofs);
    int kind;
    int t;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: t = $urandom_range(0, 65535);
      4, 5, 6:    t = int'(ofs) + $urandom_range(0, 255);
      7:          t = int'(ofs) - $urandom_range(0, 255);
      8:          t = $urandom_range(0, 1) ? 65535 : 0;
      default:    t = int'(ofs);
    endcase
    if (t > 65535) t = 65535;
    if (t < 0) t = 0;
    return t[DIFF_W-1:0];
  endfunction

  initial begin
    logic [DIFF_W-1:0] ofs;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset floor value
    send_reading(16'd0);
    send_reading(16'd1);
    send_reading(16'd2999);
    send_reading(16'd3000);
    send_reading(16'd3001);
    send_reading(16'h5555);
    send_reading(16'hAAAA);
    send_reading(16'h7FFF);
    send_reading(16'h8000);
    send_reading(16'hFFFF);
    // no offset: widest root
    write_floor(16'd0);
    send_reading(16'd0);
    send_reading(16'd1);
    send_reading(16'd2);
    send_reading(16'hFFFE);
    send_reading(16'hFFFF);
    // offset at top: everything clamps
    write_floor(16'hFFFF);
    send_reading(16'hFFFF);
    send_reading(16'd0);
    send_reading(16'h1234);
    write_floor(16'h8000);
    send_reading(16'h7FFF);
    send_reading(16'h8000);
    send_reading(16'h8001);
    send_reading(16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       ofs = 16'd0;
        1:       ofs = 16'hFFFF;
        2:       ofs = 16'd3000;
        3:       ofs = DIFF_W'($urandom_range(0, 1023));
        4:       ofs = DIFF_W'($urandom_range(60000, 65535));
        default: ofs = DIFF_W'($urandom_range(0, 65535));
      endcase
      write_floor(ofs);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p == 2) drain_results();
        send_reading(pick_reading(ofs));
      end
    end

    drain_results();
    repeat (cntdb_pkg::LATENCY + 8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cntdb_pkg.sv
rtl/core/cntdb_sqrt_stage.sv
rtl/core/cntdb_horner_step.sv
rtl/core/satellite_cn_to_db.sv
rtl/core/satellite_cn_to_db_checker.sv
tb/sv/cn_db_monitor.sv
tb/sv/tb_top.sv
